### design/assert_macros.svh
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define ASSERT_AT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

### design/jspi_pkg.sv
`default_nettype none
package jspi_pkg;

   localparam int DUTY_BITS = 14;
   localparam int AXIS_BITS = 16;
   localparam int DZ_BITS   = 16;
   localparam int DIV_BITS  = 15;

   // one sign bit and one guard bit above the wider operand
   localparam int SUM_BITS  = ((DUTY_BITS > AXIS_BITS) ? DUTY_BITS : AXIS_BITS) + 2;
   localparam int CSR_BITS  = (DUTY_BITS > DZ_BITS) ? DUTY_BITS : DZ_BITS;
   localparam int CNT_BITS  = $clog2(AXIS_BITS);

   localparam int JOINTS    = 3;
   localparam int JNT_BITS  = 2;
   localparam logic [JNT_BITS-1:0] JNT_BASE     = 2'd0;
   localparam logic [JNT_BITS-1:0] JNT_SHOULDER = 2'd1;
   localparam logic [JNT_BITS-1:0] JNT_ELBOW    = 2'd2;

   localparam int REQ_DATA_BITS = 3 * AXIS_BITS;
   localparam int RSP_DATA_BITS = ((4 * DUTY_BITS + 7) / 8) * 8;

   localparam logic [DUTY_BITS-1:0] HOME_DUTY  = DUTY_BITS'(1228);
   localparam logic [DUTY_BITS-1:0] GRIP_OPEN  = DUTY_BITS'(1150);
   localparam logic [DUTY_BITS-1:0] GRIP_CLOSE = DUTY_BITS'(1300);

   localparam logic [DZ_BITS-1:0]   DZ_RESET   = DZ_BITS'(3500);
   localparam logic [DIV_BITS-1:0]  DIV_RESET  = DIV_BITS'(7000);
   localparam logic [DUTY_BITS-1:0] BASE_MIN_RESET     = DUTY_BITS'(1050);
   localparam logic [DUTY_BITS-1:0] BASE_MAX_RESET     = DUTY_BITS'(1400);
   localparam logic [DUTY_BITS-1:0] SHOULDER_MIN_RESET = DUTY_BITS'(1150);
   localparam logic [DUTY_BITS-1:0] SHOULDER_MAX_RESET = DUTY_BITS'(1320);
   localparam logic [DUTY_BITS-1:0] ELBOW_MIN_RESET    = DUTY_BITS'(1120);
   localparam logic [DUTY_BITS-1:0] ELBOW_MAX_RESET    = DUTY_BITS'(1350);

   typedef enum logic [2:0] {
      REG_DEADZONE     = 3'd0,
      REG_SPEED_DIV    = 3'd1,
      REG_BASE_MIN     = 3'd2,
      REG_BASE_MAX     = 3'd3,
      REG_SHOULDER_MIN = 3'd4,
      REG_SHOULDER_MAX = 3'd5,
      REG_ELBOW_MIN    = 3'd6,
      REG_ELBOW_MAX    = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic                capture;
      logic                load;
      logic                step;
      logic                commit;
      logic                publish;
      logic [JNT_BITS-1:0] joint;
   } cmd_type;

   typedef struct packed {
      logic rsp_busy;
   } sts_type;

endpackage
`default_nettype wire

### design/jspi_ctrl.sv
`default_nettype none
`include "assert_macros.svh"
module jspi_ctrl
   import jspi_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_tvalid,
   output logic         req_tready,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   typedef enum logic [4:0] {
      S_IDLE    = 5'b00001,
      S_LOAD    = 5'b00010,
      S_DIV     = 5'b00100,
      S_COMMIT  = 5'b01000,
      S_PUBLISH = 5'b10000
   } state_type;

   state_type           state_ff, state_in;
   logic [JNT_BITS-1:0] jnt_ff, jnt_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in    = state_ff;
      jnt_in      = jnt_ff;
      cnt_in      = cnt_ff;
      req_tready  = 1'b0;
      cmd         = '0;
      cmd.joint   = jnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               jnt_in      = JNT_BASE;
               state_in    = S_LOAD;
            end
         end
         S_LOAD: begin
            cmd.load = 1'b1;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(AXIS_BITS - 1)) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            if (jnt_ff == JNT_ELBOW) begin
               state_in = S_PUBLISH;
            end else begin
               jnt_in   = jnt_ff + 1'b1;
               state_in = S_LOAD;
            end
         end
         S_PUBLISH: begin
            // hold the finished item until the output register frees up
            if (!sts.rsp_busy) begin
               cmd.publish = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         jnt_ff   <= JNT_BASE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         jnt_ff   <= jnt_in;
         cnt_ff   <= cnt_in;
      end
   end

   `ASSERT_NEVER(a_jnt_range, clock, reset, jnt_ff > JNT_ELBOW, "joint index out of range")
   `ASSERT_AT(a_last_commit_publishes, clock, reset,
      cmd.commit && (jnt_ff == JNT_ELBOW) |=> state_ff == S_PUBLISH,
      "last joint commit did not lead to publish")
   `ASSERT_AT(a_div_full_length, clock, reset,
      cmd.commit |-> $past(cmd.step) && ($past(cnt_ff) == CNT_BITS'(AXIS_BITS - 1)),
      "commit without a full division")

endmodule
`default_nettype wire

### design/jspi_datapath.sv
`default_nettype none
`include "assert_macros.svh"
module jspi_datapath
   import jspi_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_we,
   input  wire logic [2:0]               csr_index,
   input  wire logic [CSR_BITS-1:0]      csr_wdata,
   input  wire logic [REQ_DATA_BITS-1:0] req_tdata,
   input  wire logic                     req_tuser,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0]      rsp_tdata,
   input  wire cmd_type                  cmd,
   output sts_type                       sts
);

   // configuration
   logic [DZ_BITS-1:0]   dz_ff;
   logic [DIV_BITS-1:0]  div_ff;
   logic [DUTY_BITS-1:0] min_ff [JOINTS];
   logic [DUTY_BITS-1:0] max_ff [JOINTS];

   // captured item
   logic [AXIS_BITS-1:0] axis_ff [JOINTS];
   logic                 close_ff;

   // joint state
   logic [DUTY_BITS-1:0] pos_ff [JOINTS];

   // shared serial divider
   logic [DIV_BITS-1:0]  rem_ff, rem_in;
   logic [AXIS_BITS-1:0] quo_ff, quo_in;
   logic                 neg_ff, zero_ff;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DUTY_BITS-1:0] out_ff [4];

   logic [AXIS_BITS-1:0] axis_cur, mag;
   logic [DUTY_BITS-1:0] pos_cur, lim_lo, lim_hi, pos_new;
   logic [DIV_BITS:0]    trial;
   logic                 trial_ge;
   logic [SUM_BITS-1:0]  quo_ext;
   logic signed [SUM_BITS-1:0] step_s, sum_s, lo_s, hi_s;

   always_comb begin
      unique case (cmd.joint)
         JNT_SHOULDER: begin
            axis_cur = axis_ff[1];
            pos_cur  = pos_ff[1];
            lim_lo   = min_ff[1];
            lim_hi   = max_ff[1];
         end
         JNT_ELBOW: begin
            axis_cur = axis_ff[2];
            pos_cur  = pos_ff[2];
            lim_lo   = min_ff[2];
            lim_hi   = max_ff[2];
         end
         default: begin
            axis_cur = axis_ff[0];
            pos_cur  = pos_ff[0];
            lim_lo   = min_ff[0];
            lim_hi   = max_ff[0];
         end
      endcase
   end

   // magnitude of the most negative axis still fits as unsigned
   assign mag = axis_cur[AXIS_BITS-1] ? (~axis_cur + 1'b1) : axis_cur;

   // one restoring step per cycle
   assign trial    = {rem_ff, quo_ff[AXIS_BITS-1]};
   assign trial_ge = trial >= {1'b0, div_ff};

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (cmd.load) begin
         rem_in = '0;
         quo_in = mag;
      end else if (cmd.step) begin
         rem_in = trial_ge ? DIV_BITS'(trial - {1'b0, div_ff}) : trial[DIV_BITS-1:0];
         quo_in = {quo_ff[AXIS_BITS-2:0], trial_ge};
      end
   end

   assign quo_ext = SUM_BITS'(quo_ff);
   assign step_s  = zero_ff ? '0 : (neg_ff ? $signed(-quo_ext) : $signed(quo_ext));
   assign sum_s   = $signed(SUM_BITS'(pos_cur)) + step_s;
   assign lo_s    = $signed(SUM_BITS'(lim_lo));
   assign hi_s    = $signed(SUM_BITS'(lim_hi));

   // minimum wins over maximum
   always_comb begin
      priority if (sum_s < lo_s) begin
         pos_new = lim_lo;
      end else if (sum_s > hi_s) begin
         pos_new = lim_hi;
      end else begin
         pos_new = sum_s[DUTY_BITS-1:0];
      end
   end

   assign rsp_valid_in = cmd.publish ? 1'b1 : (rsp_valid_ff && !rsp_tready);
   assign sts.rsp_busy = rsp_valid_ff && !rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         dz_ff        <= DZ_RESET;
         div_ff       <= DIV_RESET;
         min_ff[0]    <= BASE_MIN_RESET;
         max_ff[0]    <= BASE_MAX_RESET;
         min_ff[1]    <= SHOULDER_MIN_RESET;
         max_ff[1]    <= SHOULDER_MAX_RESET;
         min_ff[2]    <= ELBOW_MIN_RESET;
         max_ff[2]    <= ELBOW_MAX_RESET;
         pos_ff[0]    <= HOME_DUTY;
         pos_ff[1]    <= HOME_DUTY;
         pos_ff[2]    <= HOME_DUTY;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (reg_index_type'(csr_index))
               REG_DEADZONE:     dz_ff     <= csr_wdata[DZ_BITS-1:0];
               REG_SPEED_DIV:    div_ff    <= csr_wdata[DIV_BITS-1:0];
               REG_BASE_MIN:     min_ff[0] <= csr_wdata[DUTY_BITS-1:0];
               REG_BASE_MAX:     max_ff[0] <= csr_wdata[DUTY_BITS-1:0];
               REG_SHOULDER_MIN: min_ff[1] <= csr_wdata[DUTY_BITS-1:0];
               REG_SHOULDER_MAX: max_ff[1] <= csr_wdata[DUTY_BITS-1:0];
               REG_ELBOW_MIN:    min_ff[2] <= csr_wdata[DUTY_BITS-1:0];
               REG_ELBOW_MAX:    max_ff[2] <= csr_wdata[DUTY_BITS-1:0];
               default: ;
            endcase
         end
         if (cmd.commit) begin
            for (int j = 0; j < JOINTS; j++) begin
               if (cmd.joint == JNT_BITS'(j)) begin
                  pos_ff[j] <= pos_new;
               end
            end
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (cmd.capture) begin
         axis_ff[0] <= req_tdata[AXIS_BITS-1:0];
         axis_ff[1] <= req_tdata[2*AXIS_BITS-1:AXIS_BITS];
         axis_ff[2] <= req_tdata[3*AXIS_BITS-1:2*AXIS_BITS];
         close_ff   <= req_tuser;
      end
      if (cmd.load) begin
         neg_ff  <= axis_cur[AXIS_BITS-1];
         // deadzone is strict, and a zero divisor holds the joint
         zero_ff <= (mag < dz_ff) || (div_ff == '0);
      end
      if (cmd.publish) begin
         out_ff[0] <= pos_ff[0];
         out_ff[1] <= pos_ff[1];
         out_ff[2] <= pos_ff[2];
         out_ff[3] <= close_ff ? GRIP_CLOSE : GRIP_OPEN;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'({out_ff[3], out_ff[2], out_ff[1], out_ff[0]});

   `ASSERT_AT(a_clamped, clock, reset,
      cmd.commit && (lim_lo <= lim_hi) |=>
         (pos_ff[$past(cmd.joint)] >= $past(lim_lo)) &&
         (pos_ff[$past(cmd.joint)] <= $past(lim_hi)),
      "committed position outside joint limits")
   `ASSERT_AT(a_valid_from_publish, clock, reset,
      $rose(rsp_tvalid) |-> $past(cmd.publish),
      "result appeared without publish")

endmodule
`default_nettype wire

### design/joystick_servo_position_integrator_core.sv
`default_nettype none
// Integrates three joystick axes into base, shoulder and elbow servo duties and
// picks the fixed gripper duty. An item's result goes valid once it is published,
// and the next item can be accepted in the cycle in which that result goes valid.
// One shared restoring divider works through the three axes in turn at one
// quotient bit per cycle. Each axis also needs a load and a commit step, and each
// item needs an accept and a publish step; publish waits while the output register
// is still held. A new item is taken once the previous one has been published
// to the output register; that register holds the result until the consumer
// takes it. The registers on the csr port must be written only while no item is
// in flight; the block itself does not enforce this.
module joystick_servo_position_integrator_core
   import jspi_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_we,
   input  wire logic [2:0]               csr_index,
   input  wire logic [CSR_BITS-1:0]      csr_wdata,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   // base_axis, shoulder_axis, elbow_axis
   input  wire logic [REQ_DATA_BITS-1:0] req_tdata,
   // close_gripper
   input  wire logic                     req_tuser,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   // base_duty, shoulder_duty, elbow_duty, grip_duty
   output logic [RSP_DATA_BITS-1:0]      rsp_tdata
);

   cmd_type cmd;
   sts_type sts;

   jspi_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   jspi_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule
`default_nettype wire
